### src/pfs_pkg.sv
// Package for printf_format_stream: payload structs, command codes,
// controller/datapath command and status structs. No dependencies.
package pfs_pkg;
    localparam logic [1:0] CMD_FMT = 2'd0;
    localparam logic [1:0] CMD_STR = 2'd1;
    localparam logic [1:0] CMD_END = 2'd2;
    localparam int DigitMax = 16;
    localparam int DigitW = 5;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_byte;
        logic [63:0] arg_value;
        logic        arg_null;
    } t_in;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        last;
        logic        is_end;
        logic [31:0] total_count;
    } t_out;

    // datapath source selection for the output byte
    localparam logic [1:0] SRC_CHAR = 2'd0;
    localparam logic [1:0] SRC_DIGIT = 2'd1;
    localparam logic [1:0] SRC_END = 2'd2;

    typedef struct packed {
        logic       load;      // capture request, start conversion
        logic       emit;      // push one result
        logic [1:0] src;
        logic [7:0] chr;
        logic       last;
        logic       cnt_bump;  // count one without result
        logic       cnt_clr;
        logic       dec_step;  // one divide-by-10 step
        logic       hex_mode;
        logic       upper;
    } t_cmd;

    typedef struct packed {
        logic                dec_done;
        logic [DigitW-1:0]   ndig;
        logic                out_busy;
    } t_sts;

    function automatic logic [7:0] hex_char(input logic [3:0] d, input logic up);
        if (d < 4'd10) return 8'h30 + {4'd0, d};
        return (up ? 8'h37 : 8'h57) + {4'd0, d};
    endfunction
endpackage

### src/printf_format_stream.sv
// printf_format_stream: streaming printf-style formatter.
// The first result is registered from the request; results follow one per cycle while
// the output is not stalled. Decimal runs the divide-by-10 loop (one digit per step,
// up to 10) before digits stream out; hex passes a setup state, a pointer gives up to
// 18 results; an end report is followed by a count-clear state. Input stalls until a
// request's last result is registered (past the clear for an end report) and while
// the output stalls. Synchronous reset (i_rst_n low) clears % flag, count, o_valid.
module printf_format_stream (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  pfs_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output pfs_pkg::t_out o_data
);
    import pfs_pkg::*;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [63:0] w_val;

    // negate negative d/i values before the divide loop; pointer keeps all 64 bits
    always_comb begin
        w_val = {32'd0, i_data.arg_value[31:0]};
        if (i_data.char_byte == "p") w_val = i_data.arg_value;
        else if ((i_data.char_byte == "d" || i_data.char_byte == "i")
                 && i_data.arg_value[31])
            w_val = {32'd0, (~i_data.arg_value[31:0]) + 32'd1};
    end

    pfs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_data(i_data), .o_cmd(w_cmd), .i_sts(w_sts)
    );
    pfs_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_val(w_val),
        .o_sts(w_sts), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall)
    );
endmodule

### src/pfs_datapath.sv
// Datapath: digit generation (one divide-by-10 per cycle), digit buffer,
// character counter and output register. Uses pfs_pkg.
module pfs_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pfs_pkg::t_cmd  i_cmd,
    input  logic [63:0]    i_val,
    output pfs_pkg::t_sts  o_sts,
    output logic           o_valid,
    output pfs_pkg::t_out  o_data,
    input  logic           i_stall
);
    import pfs_pkg::*;
    logic [63:0] r_val;
    logic [3:0]  r_dig [DigitMax];
    logic [DigitW-1:0] r_ndig;
    logic [31:0] r_cnt;
    logic        r_valid;
    t_out        r_out;
    logic        r_upper;
    logic [31:0] q;
    logic [35:0] prod;
    logic [3:0]  rem;
    logic [31:0] n_cnt;

    // v/10 via reciprocal: floor(v*0xCCCCCCCD >> 35)
    logic [63:0] mul;
    assign mul  = {32'd0, r_val[31:0]} * 64'h0000_0000_CCCC_CCCD;
    assign q    = {3'd0, mul[63:35]};
    assign prod = {4'd0, q} * 36'd10;
    assign rem  = 4'(r_val[31:0] - prod[31:0]);

    assign o_sts.dec_done = (r_val[31:0] == 32'd0) && (r_ndig != '0);
    assign o_sts.ndig = r_ndig;
    assign o_sts.out_busy = r_valid && i_stall;
    assign n_cnt = (r_cnt == 32'hFFFF_FFFF) ? r_cnt : r_cnt + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
            r_ndig  <= '0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            if (i_cmd.load) begin
                r_val   <= i_val;
                r_upper <= i_cmd.upper;
                r_ndig  <= '0;
                if (i_cmd.hex_mode) begin
                    r_ndig <= '0;
                end
            end else if (i_cmd.dec_step) begin
                r_dig[r_ndig[3:0]] <= rem;
                r_ndig <= r_ndig + 1'b1;
                r_val  <= {32'd0, q};
            end
            if (i_cmd.load && i_cmd.hex_mode) begin
                for (int k = 0; k < DigitMax; k++) r_dig[k] <= i_val[4*k +: 4];
            end
            if (i_cmd.cnt_bump) r_cnt <= n_cnt;
            if (i_cmd.emit) begin
                r_valid <= 1'b1;
                r_out.last <= i_cmd.last;
                r_out.is_end <= (i_cmd.src == SRC_END);
                case (i_cmd.src)
                    SRC_DIGIT: r_out.out_char <= hex_char(r_dig[i_cmd.chr[3:0]], r_upper);
                    SRC_END:   r_out.out_char <= 8'd0;
                    default:   r_out.out_char <= i_cmd.chr;
                endcase
                // end report includes a trailing percent bumped in the same cycle
                if (i_cmd.src == SRC_END)
                    r_out.total_count <= i_cmd.cnt_bump ? n_cnt : r_cnt;
                else
                    r_out.total_count <= n_cnt;
                if (i_cmd.src != SRC_END) r_cnt <= n_cnt;
            end
            if (i_cmd.cnt_clr) r_cnt <= '0;
        end
    end
    assign o_valid = r_valid;
    assign o_data  = r_out;
endmodule

### src/pfs_ctrl.sv
// Controller FSM: decodes requests and sequences the datapath.
// Uses pfs_pkg.
module pfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  pfs_pkg::t_in   i_data,
    output pfs_pkg::t_cmd  o_cmd,
    input  pfs_pkg::t_sts  i_sts
);
    import pfs_pkg::*;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_PRE  = 3'd2;
    localparam logic [2:0] S_DIG  = 3'd3;
    localparam logic [2:0] S_NULL = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_pend, n_pend;
    logic [4:0] r_idx, n_idx;       // prefix/null index, or digit index
    logic [2:0] r_pre, n_pre;       // prefix kind: 0 none, 2 0x, 7 clear count
    logic [63:0] r_hv;
    logic       acc;
    logic [7:0] b;
    logic [4:0] hexn;
    logic [7:0] nullc;

    assign o_stall = (r_state != S_IDLE) || i_sts.out_busy;
    assign acc = i_valid && !o_stall;
    assign b = i_data.char_byte;

    always_comb begin
        hexn = 5'd1;
        for (int k = 1; k < DigitMax; k++)
            if (r_hv[4*k +: 4] != 4'd0) hexn = 5'(k + 1);
    end
    always_comb begin
        case (r_idx[2:0])
            3'd0: nullc = "(";
            3'd1: nullc = "n";
            3'd2: nullc = "u";
            3'd3: nullc = "l";
            3'd4: nullc = "l";
            default: nullc = ")";
        endcase
    end

    always_comb begin
        o_cmd = '0;
        n_state = r_state; n_pend = r_pend; n_idx = r_idx;
        n_pre = r_pre;
        case (r_state)
            S_IDLE: if (acc) begin
                case (i_data.command)
                    CMD_STR: begin
                        o_cmd.emit = 1'b1; o_cmd.src = SRC_CHAR;
                        o_cmd.chr = b; o_cmd.last = 1'b1;
                    end
                    CMD_END: begin
                        o_cmd.cnt_bump = r_pend;
                        o_cmd.emit = 1'b1; o_cmd.src = SRC_END; o_cmd.last = 1'b1;
                        o_cmd.cnt_clr = 1'b0;
                        n_pend = 1'b0;
                        n_state = S_PRE; n_pre = 3'd7; // clear after report
                    end
                    CMD_FMT: begin
                        if (!r_pend) begin
                            if (b == "%") n_pend = 1'b1;
                            else begin
                                o_cmd.emit = 1'b1; o_cmd.chr = b; o_cmd.last = 1'b1;
                            end
                        end else begin
                            n_pend = 1'b0;
                            n_idx = '0;
                            case (b)
                                "c", "%": begin
                                    o_cmd.emit = 1'b1; o_cmd.last = 1'b1;
                                    o_cmd.chr = (b == "c") ? i_data.arg_value[7:0] : b;
                                end
                                "s": if (i_data.arg_null) n_state = S_NULL;
                                "d", "i", "u": begin
                                    o_cmd.load = 1'b1; n_state = S_DEC;
                                    n_pre = 3'd0;
                                    if (b != "u" && i_data.arg_value[31]) begin
                                        o_cmd.emit = 1'b1; o_cmd.chr = "-";
                                    end
                                end
                                "x", "X", "p": begin
                                    o_cmd.load = 1'b1; o_cmd.hex_mode = 1'b1;
                                    o_cmd.upper = (b == "X");
                                    n_pre = (b == "p") ? 3'd2 : 3'd0;
                                    n_state = S_PRE;
                                end
                                default: o_cmd.cnt_bump = 1'b1;
                            endcase
                        end
                    end
                    default: ;
                endcase
            end
            S_DEC: begin
                if (i_sts.dec_done) begin
                    n_idx = 5'(i_sts.ndig - 1'b1); n_state = S_DIG;
                end else o_cmd.dec_step = 1'b1;
            end
            S_PRE: begin
                if (r_pre == 3'd7) begin
                    o_cmd.cnt_clr = 1'b1; n_state = S_IDLE;
                end else if (r_pre == 3'd2 && !i_sts.out_busy) begin
                    o_cmd.emit = 1'b1; o_cmd.chr = (r_idx == 5'd0) ? "0" : "x";
                    n_idx = r_idx + 1'b1;
                    if (r_idx == 5'd1) begin n_pre = 3'd0; n_idx = 5'(hexn - 1'b1);
                        n_state = S_DIG; end
                end else if (r_pre == 3'd0) begin
                    n_idx = 5'(hexn - 1'b1); n_state = S_DIG;
                end
            end
            S_DIG: if (!i_sts.out_busy) begin
                o_cmd.emit = 1'b1; o_cmd.src = SRC_DIGIT; o_cmd.chr = {3'd0, r_idx};
                o_cmd.last = (r_idx == 5'd0);
                n_idx = r_idx - 1'b1;
                if (r_idx == 5'd0) n_state = S_IDLE;
            end
            S_NULL: if (!i_sts.out_busy) begin
                o_cmd.emit = 1'b1; o_cmd.chr = nullc; o_cmd.last = (r_idx == 5'd5);
                n_idx = r_idx + 1'b1;
                if (r_idx == 5'd5) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_hv <= i_data.arg_value & ((i_data.char_byte == "p") ? 64'hFFFF_FFFF_FFFF_FFFF
                                                                       : 64'h0000_0000_FFFF_FFFF);
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pend <= 1'b0; r_idx <= '0; r_pre <= '0;
        end else begin
            r_state <= n_state; r_pend <= n_pend; r_idx <= n_idx;
            r_pre <= n_pre;
        end
    end
endmodule

### src/pfs_checker.sv
// Port checker for printf_format_stream, bound to the top level.
// Uses pfs_pkg.
module pfs_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_valid,
    input logic          i_stall,
    input pfs_pkg::t_out o_data
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_data)) else $error("held result changed");
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_end |-> o_data.last) else $error("end report not last");
    a_end_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.is_end |-> o_data.out_char == 8'd0) else $error("end char");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.is_end |-> o_data.total_count != 32'd0) else $error("zero count");
endmodule

bind printf_format_stream pfs_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
);
